### rtl/rpnse_pkg.sv
// Shared types and constants for the reverse-polish stack evaluator.
// Holds the command codes, the control states and the beat structs.
// No dependencies.
package rpnse_pkg;

   // Command codes carried by a request beat.
   typedef enum logic [2:0] {
      CMD_PUSH     = 3'd0,
      CMD_ADD      = 3'd1,
      CMD_SUB      = 3'd2,
      CMD_MUL      = 3'd3,
      CMD_DIV      = 3'd4,
      CMD_REM      = 3'd5,
      CMD_POP      = 3'd6,
      CMD_UNKNOWN  = 3'd7
   } cmd_type;

   // Sequencer states of the top level.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TAKE_B,
      ST_TAKE_A,
      ST_MUL,
      ST_DIV,
      ST_FINISH
   } state_type;

   // Fixed Q16.16 data width and the divider step count (48-bit dividend).
   localparam int DATA_WIDTH = 32;
   localparam int DIV_STEPS  = 48;

   typedef struct packed {
      logic [2:0]         command;
      logic signed [31:0] operand_value;
   } req_beat_type;

   typedef struct packed {
      logic signed [31:0] result_value;
      logic [7:0]         stack_depth;
      logic               underflow;
      logic               overflow;
      logic               zero_divisor;
      logic               unknown_command;
   } rsp_beat_type;

endpackage

### rtl/rpnse_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module rpnse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/rpnse_div.sv
// Iterative signed divider for Q16.16 divide and remainder, one quotient bit a cycle.
// Depends on rpnse_pkg for the step count.
module rpnse_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        is_rem,
   input  logic signed [31:0] dividend,
   input  logic signed [31:0] divisor,
   output logic        done,
   output logic [31:0] result
);
   import rpnse_pkg::*;

   logic        busy_ff, busy_in;
   logic        fix_ff, fix_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [47:0] dvd_ff, dvd_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] dsr_ff, dsr_in;
   logic        neg_q_ff, neg_q_in;
   logic        neg_r_ff, neg_r_in;
   logic        is_rem_ff, is_rem_in;
   logic [31:0] result_ff, result_in;

   logic [31:0] a_mag;
   logic [31:0] b_mag;
   logic [32:0] partial;
   logic [33:0] diff;

   assign a_mag   = dividend[31] ? (~dividend + 32'd1) : dividend;
   assign b_mag   = divisor[31] ? (~divisor + 32'd1) : divisor;
   assign partial = {rem_ff, dvd_ff[47]};
   assign diff    = {1'b0, partial} - {2'b00, dsr_ff};

   // Load, restoring shift-subtract steps, then sign and saturation fix-up.
   always_comb begin
      busy_in   = busy_ff;
      fix_in    = 1'b0;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      dvd_in    = dvd_ff;
      rem_in    = rem_ff;
      dsr_in    = dsr_ff;
      neg_q_in  = neg_q_ff;
      neg_r_in  = neg_r_ff;
      is_rem_in = is_rem_ff;
      result_in = result_ff;
      if (start) begin
         busy_in   = 1'b1;
         cnt_in    = 6'(DIV_STEPS - 1);
         dvd_in    = is_rem ? {16'd0, a_mag} : {a_mag, 16'd0};
         rem_in    = '0;
         dsr_in    = b_mag;
         neg_q_in  = dividend[31] ^ divisor[31];
         neg_r_in  = dividend[31];
         is_rem_in = is_rem;
      end else if (busy_ff) begin
         if (!diff[33]) begin
            rem_in = diff[31:0];
            dvd_in = {dvd_ff[46:0], 1'b1};
         end else begin
            rem_in = partial[31:0];
            dvd_in = {dvd_ff[46:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
            fix_in  = 1'b1;
         end
      end else if (fix_ff) begin
         done_in = 1'b1;
         if (is_rem_ff) begin
            result_in = neg_r_ff ? (~rem_ff + 32'd1) : rem_ff;
         end else if (!neg_q_ff) begin
            result_in = (dvd_ff[47:31] != 17'd0) ? 32'h7FFF_FFFF : dvd_ff[31:0];
         end else begin
            result_in = (dvd_ff > 48'h0000_8000_0000) ? 32'h8000_0000
                                                      : (~dvd_ff[31:0] + 32'd1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fix_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fix_ff  <= fix_in;
         done_ff <= done_in;
      end
      cnt_ff    <= cnt_in;
      dvd_ff    <= dvd_in;
      rem_ff    <= rem_in;
      dsr_ff    <= dsr_in;
      neg_q_ff  <= neg_q_in;
      neg_r_ff  <= neg_r_in;
      is_rem_ff <= is_rem_in;
      result_ff <= result_in;
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

### rtl/rpn_stack_evaluator_top.sv
// Reverse-polish evaluator over a value stack held in one synchronous RAM.
// One beat at a time: push and unknown go straight to the result beat, pop and a zero
// divisor end after one operand, the rest read two, and divide and remainder then run
// the 48 steps of the divider. A stalled result beat holds the sequencer until taken.
// Each operand comes from the RAM's registered read port; the result beat waits in an output register.
// Reset clears the stack pointer and control; stack entries are left as they are.
// Depends on rpnse_pkg, rpnse_ram and rpnse_div.
module rpn_stack_evaluator_top #(
   parameter int STACK_DEPTH = 128
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  rpnse_pkg::req_beat_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rpnse_pkg::rsp_beat_type rsp_data
);
   import rpnse_pkg::*;

   localparam int AW  = $clog2(STACK_DEPTH);
   localparam int SPW = $clog2(STACK_DEPTH + 1);

   state_type          state_ff, state_in;
   logic [SPW-1:0]     sp_ff, sp_in;
   cmd_type            cmd_ff, cmd_in;
   logic signed [31:0] opv_ff, opv_in;
   logic signed [31:0] b_ff, b_in;
   logic signed [31:0] res_ff, res_in;
   logic signed [63:0] prod_ff, prod_in;
   logic               take_ok_ff, take_ok_in;
   logic               under_ff, under_in;
   logic               zdiv_ff, zdiv_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_beat_type       rsp_data_ff, rsp_data_in;

   logic               ram_we;
   logic [AW-1:0]      ram_waddr;
   logic [31:0]        ram_wdata;
   logic [AW-1:0]      ram_raddr;
   logic [31:0]        ram_rdata;

   logic               div_start;
   logic               div_is_rem;
   logic               div_done;
   logic [31:0]        div_result;

   logic [SPW-1:0]     sp_dec;
   logic [SPW-1:0]     sp_inc;
   logic               sp_nonzero;
   logic               sp_room;
   logic [SPW+7:0]     depth_now_ext;
   logic [SPW+7:0]     depth_inc_ext;
   logic signed [31:0] rd_val;
   logic signed [32:0] sum_add;
   logic signed [32:0] sum_sub;
   logic [47:0]        prod_sh;
   logic signed [31:0] put_val;

   // Saturate a 33-bit sum to the signed 32-bit range.
   function automatic logic [31:0] sat33(input logic [32:0] v);
      if (v[32] == v[31]) begin
         return v[31:0];
      end
      return v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
   endfunction

   // Saturate a 48-bit value to the signed 32-bit range.
   function automatic logic [31:0] sat48(input logic [47:0] v);
      if ((&v[47:31]) || !(|v[47:31])) begin
         return v[31:0];
      end
      return v[47] ? 32'h8000_0000 : 32'h7FFF_FFFF;
   endfunction

   rpnse_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (STACK_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   rpnse_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .is_rem   (div_is_rem),
      .dividend (rd_val),
      .divisor  (b_ff),
      .done     (div_done),
      .result   (div_result)
   );

   // Stack pointer arithmetic; the RAM always reads the current top entry.
   assign sp_dec        = sp_ff - SPW'(1);
   assign sp_inc        = sp_ff + SPW'(1);
   assign sp_nonzero    = (sp_ff != '0);
   assign sp_room       = (sp_ff < SPW'(STACK_DEPTH));
   assign ram_raddr     = sp_dec[AW-1:0];
   assign ram_waddr     = sp_ff[AW-1:0];
   assign depth_now_ext = {8'd0, sp_ff};
   assign depth_inc_ext = {8'd0, sp_inc};

   // An operand read from an empty stack is zero.
   assign rd_val  = take_ok_ff ? ram_rdata : 32'sd0;
   assign sum_add = {rd_val[31], rd_val} + {b_ff[31], b_ff};
   assign sum_sub = {rd_val[31], rd_val} - {b_ff[31], b_ff};
   assign prod_sh = prod_ff[63:16];
   assign put_val = (cmd_ff == CMD_PUSH) ? opv_ff : res_ff;
   assign div_is_rem = (cmd_ff == CMD_REM);

   // Sequencer: next state, stack updates and the result beat.
   always_comb begin
      state_in     = state_ff;
      sp_in        = sp_ff;
      cmd_in       = cmd_ff;
      opv_in       = opv_ff;
      b_in         = b_ff;
      res_in       = res_ff;
      prod_in      = prod_ff;
      take_ok_in   = take_ok_ff;
      under_in     = under_ff;
      zdiv_in      = zdiv_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      ram_wdata    = put_val;
      div_start    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in   = cmd_type'(req_data.command);
               opv_in   = req_data.operand_value;
               under_in = 1'b0;
               zdiv_in  = 1'b0;
               unique case (cmd_type'(req_data.command)) inside
                  CMD_PUSH, CMD_UNKNOWN: begin
                     state_in = ST_FINISH;
                  end
                  default: begin
                     // Pop the right operand (or the answer).
                     take_ok_in = sp_nonzero;
                     under_in   = !sp_nonzero;
                     if (sp_nonzero) begin
                        sp_in = sp_dec;
                     end
                     state_in = ST_TAKE_B;
                  end
               endcase
            end
         end
         ST_TAKE_B: begin
            b_in = rd_val;
            if (cmd_ff == CMD_POP) begin
               state_in = ST_FINISH;
            end else if ((cmd_ff == CMD_DIV || cmd_ff == CMD_REM) && rd_val == 32'sd0) begin
               zdiv_in  = 1'b1;
               state_in = ST_FINISH;
            end else begin
               // Pop the left operand.
               take_ok_in = sp_nonzero;
               under_in   = under_ff || !sp_nonzero;
               if (sp_nonzero) begin
                  sp_in = sp_dec;
               end
               state_in = ST_TAKE_A;
            end
         end
         ST_TAKE_A: begin
            case (cmd_ff) inside
               CMD_ADD: begin
                  res_in   = sat33(sum_add);
                  state_in = ST_FINISH;
               end
               CMD_SUB: begin
                  res_in   = sat33(sum_sub);
                  state_in = ST_FINISH;
               end
               CMD_MUL: begin
                  prod_in  = rd_val * b_ff;
                  state_in = ST_MUL;
               end
               default: begin
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end
            endcase
         end
         ST_MUL: begin
            // Arithmetic shift by 16 is the floor of the Q16.16 product.
            res_in   = sat48(prod_sh);
            state_in = ST_FINISH;
         end
         ST_DIV: begin
            if (div_done) begin
               res_in   = div_result;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in                 = 1'b1;
               rsp_data_in.result_value     = 32'sd0;
               rsp_data_in.stack_depth      = depth_now_ext[7:0];
               rsp_data_in.underflow        = under_ff;
               rsp_data_in.overflow         = 1'b0;
               rsp_data_in.zero_divisor     = zdiv_ff;
               rsp_data_in.unknown_command  = 1'b0;
               case (cmd_ff) inside
                  CMD_UNKNOWN: begin
                     rsp_data_in.unknown_command = 1'b1;
                  end
                  CMD_POP: begin
                     rsp_data_in.result_value = b_ff;
                  end
                  default: begin
                     // Push the value or result unless the divisor was zero or the stack is full.
                     if (!zdiv_ff) begin
                        if (sp_room) begin
                           ram_we                   = 1'b1;
                           sp_in                    = sp_inc;
                           rsp_data_in.result_value = put_val;
                           rsp_data_in.stack_depth  = depth_inc_ext[7:0];
                        end else begin
                           rsp_data_in.overflow = 1'b1;
                        end
                     end
                  end
               endcase
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sp_ff        <= sp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      opv_ff      <= opv_in;
      b_ff        <= b_in;
      res_ff      <= res_in;
      prod_ff     <= prod_in;
      take_ok_ff  <= take_ok_in;
      under_ff    <= under_in;
      zdiv_ff     <= zdiv_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
